// ===== sv/cdsa_pkg.sv =====
// ----------------------------------------------------------------------------
// cdsa_pkg
// shared types and constants of the door sweep and wrong-card alarm block
// ----------------------------------------------------------------------------
package cdsa_pkg;

  localparam int unsigned UID_W   = 32;
  localparam int unsigned ANGLE_W = 7;
  localparam int unsigned DIST_W  = 9;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned LIMIT_W = 4;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned OUT_W   = 16;

  localparam logic [DIST_W-1:0]  SWEEP_STEP  = 9'd4;
  localparam logic [DIST_W-1:0]  HOLD_END    = 9'd308;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'd255;
  localparam logic [UID_W-1:0]   CARD_ID_RST = 32'hD45E_14B8;
  localparam logic [LIMIT_W-1:0] LIMIT_RST   = 4'd3;
  localparam logic [COUNT_W-1:0] TICKS_RST   = 8'd40;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_CARD = 1'b1
  } op_e;

  typedef enum logic [IDX_W-1:0] {
    REG_CARD_ID     = 2'd0,
    REG_WRONG_LIMIT = 2'd1,
    REG_ALARM_TICKS = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [UID_W-1:0]   card_id;
    logic [LIMIT_W-1:0] wrong_limit;
    logic [COUNT_W-1:0] alarm_ticks;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0] wrong_count;
    logic [COUNT_W-1:0] alarm_count;
    logic               sweep_active;
    logic [DIST_W-1:0]  sweep_distance;
    logic [ANGLE_W-1:0] angle_now;
    logic               buzzer_on;
  } st_t;

  // packed so that the angle sits in the lowest bits
  typedef struct packed {
    logic               card_match;
    logic               door_opening;
    logic               buzzer_level;
    logic [ANGLE_W-1:0] servo_angle;
  } res_t;

endpackage

// ===== sv/cdsa_step.sv =====
// ----------------------------------------------------------------------------
// cdsa_step
// next state and result for one word: card compare, door sweep, alarm timer
// ----------------------------------------------------------------------------
module cdsa_step #(
  parameter int unsigned CLOSED_ANGLE = 108
) (
  input  cdsa_pkg::op_e                  op_i,
  input  logic [cdsa_pkg::UID_W-1:0]     uid_i,
  input  cdsa_pkg::cfg_t                 cfg_i,
  input  cdsa_pkg::st_t                  st_i,
  output cdsa_pkg::st_t                  st_o,
  output cdsa_pkg::res_t                 res_o
);
  import cdsa_pkg::*;

  localparam logic [DIST_W-1:0] CLOSED_D  = DIST_W'(CLOSED_ANGLE);
  localparam logic [DIST_W-1:0] SWEEP_END = HOLD_END + CLOSED_D;

  logic [DIST_W-1:0] dist_adv;
  logic              match;
  st_t               door_st;

  assign dist_adv = st_i.sweep_distance + SWEEP_STEP;

  // card compare and door sweep
  always_comb begin
    door_st = st_i;
    match   = 1'b0;
    if (op_i == OP_CARD) begin
      if (uid_i == cfg_i.card_id) begin
        door_st.sweep_active = 1'b1;
        match                = 1'b1;
      end else if (st_i.wrong_count != COUNT_MAX) begin
        door_st.wrong_count = st_i.wrong_count + COUNT_W'(1);
      end
    end else if (st_i.sweep_active) begin
      door_st.sweep_distance = dist_adv;
      priority if (dist_adv < CLOSED_D) begin
        door_st.angle_now = ANGLE_W'(CLOSED_D - dist_adv);
      end else if (dist_adv < HOLD_END) begin
        door_st.angle_now = '0;
      end else if (dist_adv < SWEEP_END) begin
        door_st.angle_now = ANGLE_W'(dist_adv - HOLD_END);
      end else begin
        door_st.angle_now      = ANGLE_W'(CLOSED_ANGLE);
        door_st.sweep_distance = '0;
        door_st.sweep_active   = 1'b0;
      end
    end
  end

  // alarm timer, after the door within a tick
  always_comb begin
    st_o = door_st;
    if (op_i == OP_TICK && door_st.wrong_count >= COUNT_W'(cfg_i.wrong_limit)) begin
      st_o.buzzer_on = 1'b1;
      if (door_st.alarm_count != COUNT_MAX) begin
        st_o.alarm_count = door_st.alarm_count + COUNT_W'(1);
      end
      if (st_o.alarm_count >= cfg_i.alarm_ticks) begin
        st_o.alarm_count = '0;
        st_o.wrong_count = '0;
        st_o.buzzer_on   = 1'b0;
      end
    end
  end

  assign res_o.card_match   = match;
  assign res_o.door_opening = st_o.sweep_active;
  assign res_o.buzzer_level = st_o.buzzer_on;
  assign res_o.servo_angle  = st_o.angle_now;

endmodule

// ===== sv/card_door_sweep_alarm.sv =====
// ----------------------------------------------------------------------------
// card_door_sweep_alarm
// door access controller: card check, servo sweep and wrong-card buzzer
// ----------------------------------------------------------------------------
// Each input word is a card read (tuser 1) or a tick (tuser 0) and yields one
// output word. An accepted word sits in the input register while the step
// logic works out the next state. The output register takes the result when
// the word advances, and m_axis_tvalid then rises.
// A new word is taken every cycle while the output side keeps up. When both
// registers are full and the receiver holds off, s_axis_tready drops in that
// same cycle, so an output stall holds off the input.
// Configuration writes take effect at once; the user must make them while no
// word is in flight, as the block itself does not enforce this.
module card_door_sweep_alarm #(
  parameter int unsigned CLOSED_ANGLE = 108
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cdsa_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [cdsa_pkg::UID_W-1:0]    cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [cdsa_pkg::UID_W-1:0]    s_axis_tdata,   // card_uid[31:0]
  input  logic                          s_axis_tuser,   // operation[0]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // servo_angle[6:0], buzzer_level[7], door_opening[8], card_match[9], zero
  output logic [cdsa_pkg::OUT_W-1:0]    m_axis_tdata
);
  import cdsa_pkg::*;

  cfg_t             cfg_q;
  st_t              st_q, st_d;
  res_t             res_q, res_d;
  logic             in_valid_q, out_valid_q;
  op_e              op_q;
  logic [UID_W-1:0] uid_q;
  logic             advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.card_id     <= CARD_ID_RST;
      cfg_q.wrong_limit <= LIMIT_RST;
      cfg_q.alarm_ticks <= TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_CARD_ID:     cfg_q.card_id     <= cfg_data_i;
        REG_WRONG_LIMIT: cfg_q.wrong_limit <= cfg_data_i[LIMIT_W-1:0];
        REG_ALARM_TICKS: cfg_q.alarm_ticks <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q  <= op_e'(s_axis_tuser);
      uid_q <= s_axis_tdata;
    end
  end

  cdsa_step #(
    .CLOSED_ANGLE(CLOSED_ANGLE)
  ) u_step (
    .op_i  (op_q),
    .uid_i (uid_q),
    .cfg_i (cfg_q),
    .st_i  (st_q),
    .st_o  (st_d),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.wrong_count    <= '0;
      st_q.alarm_count    <= '0;
      st_q.sweep_active   <= 1'b0;
      st_q.sweep_distance <= '0;
      st_q.angle_now      <= ANGLE_W'(CLOSED_ANGLE);
      st_q.buzzer_on      <= 1'b0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_W - $bits(res_t))'(0), res_q};

endmodule

// ===== sv/cdsa_checker.sv =====
// ----------------------------------------------------------------------------
// cdsa_checker
// port-level checks of the door sweep and wrong-card alarm block
// ----------------------------------------------------------------------------
module cdsa_checker #(
  parameter int unsigned CLOSED_ANGLE = 108
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [cdsa_pkg::OUT_W-1:0] m_axis_tdata
);
  import cdsa_pkg::*;

  res_t res;
  assign res = m_axis_tdata[$bits(res_t)-1:0];

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_match_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.card_match |-> res.door_opening)
    else $error("card match without door sweep");

  a_closed_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res.door_opening |-> res.servo_angle == ANGLE_W'(CLOSED_ANGLE))
    else $error("door idle but servo not closed");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res.servo_angle <= ANGLE_W'(CLOSED_ANGLE))
    else $error("servo angle beyond closed angle");

  a_accept_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
    else $error("accepted word produced no output");

endmodule

bind card_door_sweep_alarm cdsa_checker #(
  .CLOSED_ANGLE(CLOSED_ANGLE)
) u_cdsa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
